/* hdl/be3_pkg.sv */
// Package for the 3x3 binary erosion block: field widths, window masks,
// configuration register indexes and the line store entry type.
// Depends on nothing; used by the line store memory and the top level.
package be3_pkg;

  localparam int CFG_W      = 11;
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int COUNT_W    = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_DATA_W = 56;

  localparam logic [PIX_W-1:0]   WHITE_LEVEL = 8'd255;
  localparam logic [8:0]         CROSS_MASK  = 9'h0BA;
  localparam logic [8:0]         SQUARE_MASK = 9'h1FF;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 21'h1FFFFF;
  localparam logic [CFG_W-1:0]   MIN_SIZE    = 11'd3;
  localparam logic [CFG_W-1:0]   RESET_SIZE  = 11'd950;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_SQUARE_MODE  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic upper;
    logic middle;
  } line_bits_t;

endpackage

/* hdl/be3_line_ram.sv */
// Line store memory: one entry per column holding the upper and middle row bits.
// One write port and one registered read port; uses be3_pkg for the entry type.
module be3_line_ram
  import be3_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  line_bits_t    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output line_bits_t    rd_data
);

  line_bits_t mem [DEPTH];
  line_bits_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/binary_erosion_3x3_counter.sv */
// Top level of the 3x3 binary erosion block with per-frame survivor count.
// A result passes the input stage register and then the output register; in pixels
// the output lags the input by one row plus one pixel. Throughput: one pixel per cycle
// while the output is not stalled, set by the single read and write port of the line store.
// Reset clears all control state, then a clearing pass over every entry zeroes
// the line store while no input transaction is taken; configuration is taken at any time.
module binary_erosion_3x3_counter
  import be3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,    // [7:0] pixel_value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [7:0] eroded_pixel, [17:8] out_column,
                                             // [27:18] out_row, [48:28] white_total
  output logic                  out_tlast,   // frame_last
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SW = CW + 1;
  localparam int SH = RW + 1;

  logic [CFG_W-1:0] cfg_width_r, cfg_height_r;
  logic             cfg_square_r;
  logic [SW-1:0]    w_use;
  logic [SH-1:0]    h_use;

  logic          clr_active_r, clr_active_nxt;
  logic [CW-1:0] clr_addr_r, clr_addr_nxt;

  logic [CW-1:0] col_r, col_nxt, a_col;
  logic [RW-1:0] row_r, row_nxt, a_row;
  logic          pos_wrap, col_end, row_end;
  logic          in_acc;

  logic          b_valid_r, b_valid_nxt;
  logic [CW-1:0] b_col_r;
  logic [RW-1:0] b_row_r;
  logic          b_white_r;
  logic          b_adv, b_go;

  line_bits_t    rd_data, wr_data;
  logic          wr_en;
  logic [CW-1:0] wr_addr;

  logic [8:0]         window_r, window_nxt, mask;
  logic [COUNT_W-1:0] count_r, count_nxt, count_base;
  logic               emit, keep, frame_last;
  logic [CW-1:0]      ocol;
  logic [RW-1:0]      orow;

  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   out_pix_r;
  logic [COORD_W-1:0] out_col_r, out_row_r;
  logic [COUNT_W-1:0] out_total_r;
  logic               out_last_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= RESET_SIZE;
      cfg_height_r <= RESET_SIZE;
      cfg_square_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_IMAGE_WIDTH:  cfg_width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: cfg_height_r <= cfg_data;
        CFG_SQUARE_MODE:  cfg_square_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_width_r < MIN_SIZE) begin
      w_use = SW'(MIN_SIZE);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      w_use = SW'(MAX_WIDTH);
    end else begin
      w_use = SW'(cfg_width_r);
    end
    if (cfg_height_r < MIN_SIZE) begin
      h_use = SH'(MIN_SIZE);
    end else if (32'(cfg_height_r) > 32'(MAX_HEIGHT)) begin
      h_use = SH'(MAX_HEIGHT);
    end else begin
      h_use = SH'(cfg_height_r);
    end
  end

  // Line store clearing pass after reset.
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      if (clr_addr_r == CW'(MAX_WIDTH - 1)) begin
        clr_active_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  // Input stage: position of the accepted pixel and the line store read.
  assign b_adv     = !out_valid_r || out_tready;
  assign b_go      = b_valid_r && b_adv;
  assign in_tready = !clr_active_r && (!b_valid_r || b_adv);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    pos_wrap = (SW'(col_r) >= w_use) || (SH'(row_r) >= h_use);
    a_col    = pos_wrap ? '0 : col_r;
    a_row    = pos_wrap ? '0 : row_r;
    col_end  = (SW'(a_col) + SW'(1)) >= w_use;
    row_end  = (SH'(a_row) + SH'(1)) >= h_use;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (in_acc) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : a_row + RW'(1);
      end else begin
        col_nxt = a_col + CW'(1);
        row_nxt = a_row;
      end
    end
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (in_acc) begin
      b_valid_nxt = 1'b1;
    end else if (b_adv) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      b_valid_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_col_r   <= a_col;
      b_row_r   <= a_row;
      b_white_r <= (in_tdata == WHITE_LEVEL);
    end
  end

  // Line store: the window stage writes back the column it has just read.
  always_comb begin
    wr_en          = clr_active_r || b_go;
    wr_addr        = clr_active_r ? clr_addr_r : b_col_r;
    wr_data.upper  = clr_active_r ? 1'b0 : rd_data.middle;
    wr_data.middle = clr_active_r ? 1'b0 : b_white_r;
  end

  be3_line_ram #(
    .DEPTH(MAX_WIDTH),
    .AW   (CW)
  ) u_line_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (in_acc),
    .rd_addr(a_col),
    .rd_data(rd_data)
  );

  // Window stage: shift in the new column, decide and count.
  always_comb begin
    window_nxt = {window_r[5:0], b_white_r, rd_data.middle, rd_data.upper};
    mask       = cfg_square_r ? SQUARE_MASK : CROSS_MASK;
    emit       = (b_row_r > RW'(1)) || ((b_row_r == RW'(1)) && (b_col_r != '0));
    keep       = (b_row_r > RW'(1)) && (b_col_r > CW'(1)) && ((window_nxt & mask) == mask);
    if (b_col_r != '0) begin
      ocol = b_col_r - CW'(1);
      orow = b_row_r - RW'(1);
    end else begin
      ocol = CW'(w_use - SW'(1));
      orow = b_row_r - RW'(2);
    end
    frame_last = (SH'(b_row_r) == h_use - SH'(1)) && (SW'(b_col_r) == w_use - SW'(1));
    count_base = ((b_row_r == '0) && (b_col_r == '0)) ? '0 : count_r;
    count_nxt  = (keep && (count_base != COUNT_MAX)) ? count_base + COUNT_W'(1) : count_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      count_r  <= '0;
    end else if (b_go) begin
      window_r <= window_nxt;
      count_r  <= count_nxt;
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (b_adv) begin
      out_valid_nxt = b_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      out_pix_r   <= keep ? WHITE_LEVEL : '0;
      out_col_r   <= COORD_W'(ocol);
      out_row_r   <= COORD_W'(orow);
      out_total_r <= count_nxt;
      out_last_r  <= frame_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_total_r, out_row_r, out_col_r, out_pix_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_tready)
    else $error("input taken during line store clearing pass");

  a_clear_full_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_active_r) |-> $past(clr_addr_r) == CW'(MAX_WIDTH - 1))
    else $error("clearing pass ended before the last entry");

  a_pixel_binary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pix_r == '0) || (out_pix_r == WHITE_LEVEL))
    else $error("result pixel is neither 0 nor 255");

  a_white_interior: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_pix_r == WHITE_LEVEL)) |->
      (out_col_r != '0) && (out_row_r != '0) && (out_total_r != '0))
    else $error("white result on the frame border or with a zero count");
`endif

endmodule

/* sim/erosion_checker.sv */
// Checker for the 3x3 binary erosion block: predicts each result pixel from accepted
// input and configuration transactions and compares it with the output channel.
// Depends on be3_pkg for field widths, masks and register indexes.
`timescale 1ns / 100ps

module erosion_checker
  import be3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output int                    error_count,
  output int                    results_outstanding
);

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COUNT_W-1:0] total;
    logic               last;
  } eroded_result_t;

  eroded_result_t     expected_pixels[$];
  logic               upper_line [MAX_WIDTH];
  logic               middle_line[MAX_WIDTH];
  logic [8:0]         window;
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [COUNT_W-1:0] survivors;
  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  logic               square_reg;
  int                 mismatches = 0;

  assign error_count = mismatches;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < MIN_SIZE) return 32'(MIN_SIZE);
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 100)
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic erode_step(input logic [PIX_W-1:0] pix);
    int unsigned    w;
    int unsigned    h;
    int unsigned    r;
    int unsigned    c;
    logic           top;
    logic           mid;
    logic           bot;
    logic           keep;
    logic [8:0]     mask;
    eroded_result_t res;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    // A position left outside a smaller size restarts the frame.
    if (col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    if (r == 0 && c == 0) survivors = '0;
    bot = (pix == WHITE_LEVEL);
    top = upper_line[c];
    mid = middle_line[c];
    upper_line[c]  = mid;
    middle_line[c] = bot;
    window = {window[5:0], bot, mid, top};
    if (r >= 2 || (r == 1 && c >= 1)) begin
      if (c >= 1) begin
        res.row = COORD_W'(r - 1);
        res.col = COORD_W'(c - 1);
      end else begin
        res.row = COORD_W'(r - 2);
        res.col = COORD_W'(w - 1);
      end
      mask = square_reg ? SQUARE_MASK : CROSS_MASK;
      keep = (r >= 2 && c >= 2) && ((window & mask) == mask);
      if (keep && survivors != COUNT_MAX) survivors++;
      res.pixel = keep ? WHITE_LEVEL : '0;
      res.total = survivors;
      res.last  = (r == h - 1 && c == w - 1);
      expected_pixels.push_back(res);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_result();
    eroded_result_t want;
    string          loc;
    if (expected_pixels.size() == 0) begin
      report_mismatch("unexpected result, row", out_tdata[27:18], 0);
      return;
    end
    want = expected_pixels.pop_front();
    loc = $sformatf(" at row %0d col %0d", want.row, want.col);
    if (out_tdata[7:0] != want.pixel)
      report_mismatch({"eroded_pixel", loc}, out_tdata[7:0], want.pixel);
    if (out_tdata[17:8] != want.col)
      report_mismatch({"out_column", loc}, out_tdata[17:8], want.col);
    if (out_tdata[27:18] != want.row)
      report_mismatch({"out_row", loc}, out_tdata[27:18], want.row);
    if (out_tdata[48:28] != want.total)
      report_mismatch({"white_total", loc}, out_tdata[48:28], want.total);
    if (out_tlast != want.last)
      report_mismatch({"frame_last", loc}, out_tlast, want.last);
    if (out_tdata[OUT_DATA_W-1:49] != '0)
      report_mismatch({"tdata padding", loc}, out_tdata[OUT_DATA_W-1:49], 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_pixels.delete();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i]  = 1'b0;
        middle_line[i] = 1'b0;
      end
      window     = '0;
      col_pos    = 0;
      row_pos    = 0;
      survivors  = '0;
      width_reg  = RESET_SIZE;
      height_reg = RESET_SIZE;
      square_reg = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_reg  = cfg_data;
          CFG_IMAGE_HEIGHT: height_reg = cfg_data;
          CFG_SQUARE_MODE:  square_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) erode_step(in_tdata);
    end
    results_outstanding <= expected_pixels.size();
  end

endmodule

/* sim/testbench.sv */
// Testbench top for binary_erosion_3x3_counter: drives pixel and configuration
// transactions with random idling and stalls, and gives the verdict.
// Depends on be3_pkg, the block itself and erosion_checker.
`timescale 1ns / 100ps

module testbench
  import be3_pkg::*;
();

  localparam int                   CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_data   = '0;

  int   error_count;
  int   results_outstanding;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic rx_hold       = 1'b0;
  int   cycle_count   = 0;

  binary_erosion_3x3_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  erosion_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .out_tlast           (out_tlast),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .error_count         (error_count),
    .results_outstanding (results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [PIX_W-1:0] next_pixel(input int unsigned white_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < white_pct) return WHITE_LEVEL;
    if (roll < white_pct + (100 - white_pct) / 2) return '0;
    return PIX_W'($urandom_range(255));
  endfunction

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(15))
      0:       return CFG_W'($urandom_range(2));
      1:       return MIN_SIZE;
      default: return CFG_W'($urandom_range(4, 12));
    endcase
  endfunction

  // Called at a clock edge; returns at the edge where the transaction is taken.
  task automatic push_pixel(input logic [PIX_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops sending until every expected result is out, then lets the pipeline empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic square);
    settle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_SQUARE_MODE, {(CFG_W-1)'($urandom), square});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          sent;
    int unsigned white_pct;
    int unsigned burst;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct <= 19;
    recv_idle_pct <= 78;
    @(posedge clk);

    // Sizes below the minimum clamp to a 3x3 frame; the cross keeps the center.
    load_config(11'd0, 11'd1, 1'b0);
    repeat (9) push_pixel(WHITE_LEVEL);
    // A corner one below white removes the center under the square.
    load_config(MIN_SIZE, MIN_SIZE, 1'b1);
    push_pixel(8'd254);
    repeat (8) push_pixel(WHITE_LEVEL);
    settle();
    write_reg(CFG_UNUSED, 11'h7FF);
    cfg_valid <= 1'b0;
    // Shrinking the width mid-row puts the position out of range and restarts the frame.
    load_config(11'd5, 11'd4, 1'b0);
    repeat (4) push_pixel(WHITE_LEVEL);
    load_config(MIN_SIZE, 11'd4, 1'b0);
    push_pixel(8'd0);
    push_pixel(8'd1);
    push_pixel(8'd128);

    for (int era = 0; era < 3; era++) begin
      case (era)
        0: begin
          send_idle_pct <= 19;
          recv_idle_pct <= 78;
        end
        1: begin
          send_idle_pct <= 78;
          recv_idle_pct <= 19;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      sent = 0;
      while (sent < 250) begin
        load_config(pick_size(), pick_size(), 1'($urandom_range(1)));
        white_pct = $urandom_range(50, 97);
        burst = $urandom_range(15, 90);
        repeat (burst) push_pixel(next_pixel(white_pct));
        sent += burst;
      end
    end

    // Long receiver stall while pixels keep coming, so the input side backs up.
    load_config(11'd6, 11'd5, 1'b1);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
      end
      repeat (80) push_pixel(next_pixel(90));
    join
    settle();
    repeat (40) push_pixel(next_pixel(90));

    // Register values at and above the limits give the widest and tallest frame.
    load_config(11'h7FF, 11'd1024, 1'b0);
    repeat (24) push_pixel(next_pixel(97));

    settle();
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
